// File: hw/rtl/roulette_wheel_selector_assert.svh
// assertion macros used by the checker file
`ifndef ROULETTE_WHEEL_SELECTOR_ASSERT_SVH
`define ROULETTE_WHEEL_SELECTOR_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define RWS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define RWS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/rws_pkg.sv
package rws_pkg;

    // field widths
    localparam int FIT_W    = 16;
    localparam int SUM_W    = 24;
    localparam int PROD_W   = FIT_W + SUM_W;
    localparam int ACT_W    = 2;
    localparam int EIDX_W   = 8;
    localparam int PCNT_W   = 9;
    localparam int DSTEP_W  = 5;

    localparam logic [SUM_W-1:0]  SUM_MAX   = {SUM_W{1'b1}};
    localparam logic [FIT_W-1:0]  AVG_MAX   = {FIT_W{1'b1}};
    localparam logic [PCNT_W-1:0] PCNT_RST  = 9'd256;

    // action codes
    localparam logic [ACT_W-1:0] ACT_WR   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_STAT = 2'd1;
    localparam logic [ACT_W-1:0] ACT_SEL  = 2'd2;

    // result kinds
    localparam logic KIND_STAT = 1'b0;
    localparam logic KIND_SEL  = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic wr;
        logic start;
        logic sel;
        logic scan;
        logic div_start;
        logic load_out;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic scan_done;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

// File: hw/rtl/roulette_wheel_selector.sv
// Fitness table with statistics and roulette-wheel selection. A write word stores one
// 16-bit fitness and gives no result. A statistics word walks entries 0 to n-1 (n is
// pop_count clamped to 1..POP_MAX) through the table's single read port, one entry per
// cycle, then divides the sum by n in a bit-serial divider of 24 steps. A select word
// multiplies the fraction by the sum kept from the last statistics word and walks the
// table until the running sum reaches that limit or the walk reaches entry n-1. One word
// is in work at a time; a finished result waits in the output register while the next
// word is taken. The table has no reset: entries must be written before they are
// scanned. pop_count may only be written while no word is in work.
module roulette_wheel_selector #(
    parameter int POP_MAX = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [rws_pkg::PCNT_W-1:0]  i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [rws_pkg::ACT_W-1:0]   i_action,
    input  logic [rws_pkg::EIDX_W-1:0]  i_entry_index,
    input  logic [rws_pkg::FIT_W-1:0]   i_fitness_value,
    input  logic [rws_pkg::FIT_W-1:0]   i_random_fraction,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_result_kind,
    output logic [rws_pkg::EIDX_W-1:0]  o_picked_index,
    output logic [rws_pkg::SUM_W-1:0]   o_fit_sum,
    output logic [rws_pkg::FIT_W-1:0]   o_min_fit,
    output logic [rws_pkg::EIDX_W-1:0]  o_min_index,
    output logic [rws_pkg::FIT_W-1:0]   o_max_fit,
    output logic [rws_pkg::EIDX_W-1:0]  o_max_index,
    output logic [rws_pkg::FIT_W-1:0]   o_avg_fit
);
    import rws_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    // sequencer
    rws_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_action),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    // table, accumulators, divider and output register
    rws_dp #(
        .POP_MAX (POP_MAX)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_data        (i_cfg_data),
        .i_entry_index     (i_entry_index),
        .i_fitness_value   (i_fitness_value),
        .i_random_fraction (i_random_fraction),
        .i_out_ready       (i_out_ready),
        .o_out_valid       (o_out_valid),
        .o_result_kind     (o_result_kind),
        .o_picked_index    (o_picked_index),
        .o_fit_sum         (o_fit_sum),
        .o_min_fit         (o_min_fit),
        .o_min_index       (o_min_index),
        .o_max_fit         (o_max_fit),
        .o_max_index       (o_max_index),
        .o_avg_fit         (o_avg_fit)
    );

endmodule

// File: hw/rtl/rws_div.sv
module rws_div #(
    parameter int DVS_W = 9
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [rws_pkg::SUM_W-1:0] i_dividend,
    input  logic [DVS_W-1:0]          i_divisor,
    output logic                      o_done,
    output logic [rws_pkg::SUM_W-1:0] o_quotient
);
    import rws_pkg::*;

    localparam logic [DSTEP_W-1:0] STEP_LAST = DSTEP_W'(SUM_W - 1);

    logic               r_busy;
    logic               r_done;
    logic [DSTEP_W-1:0] r_step;
    logic [DVS_W-1:0]   r_rem;
    logic [SUM_W-1:0]   r_quo;
    logic [DVS_W:0]     trial;
    logic [DVS_W:0]     diff;
    logic               q_bit;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        trial = {r_rem, r_quo[SUM_W-1]};
        diff  = trial - {1'b0, i_divisor};
        q_bit = (trial >= {1'b0, i_divisor});
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= r_busy && (r_step == STEP_LAST);
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + DSTEP_W'(1);
                if (r_step == STEP_LAST) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= q_bit ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            r_quo <= {r_quo[SUM_W-2:0], q_bit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// File: hw/rtl/rws_dp.sv
module rws_dp #(
    parameter int POP_MAX = 256
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  rws_pkg::t_cmd              i_cmd,
    output rws_pkg::t_sts              o_sts,
    input  logic                       i_cfg_valid,
    input  logic [rws_pkg::PCNT_W-1:0] i_cfg_data,
    input  logic [rws_pkg::EIDX_W-1:0] i_entry_index,
    input  logic [rws_pkg::FIT_W-1:0]  i_fitness_value,
    input  logic [rws_pkg::FIT_W-1:0]  i_random_fraction,
    input  logic                       i_out_ready,
    output logic                       o_out_valid,
    output logic                       o_result_kind,
    output logic [rws_pkg::EIDX_W-1:0] o_picked_index,
    output logic [rws_pkg::SUM_W-1:0]  o_fit_sum,
    output logic [rws_pkg::FIT_W-1:0]  o_min_fit,
    output logic [rws_pkg::EIDX_W-1:0] o_min_index,
    output logic [rws_pkg::FIT_W-1:0]  o_max_fit,
    output logic [rws_pkg::EIDX_W-1:0] o_max_index,
    output logic [rws_pkg::FIT_W-1:0]  o_avg_fit
);
    import rws_pkg::*;

    localparam int IDX_W = $clog2(POP_MAX);
    localparam int CNT_W = $clog2(POP_MAX + 1);

    // fitness table
    logic [FIT_W-1:0]  mem [POP_MAX];
    logic [FIT_W-1:0]  r_rd_data;
    logic [IDX_W-1:0]  rd_addr;
    logic [IDX_W-1:0]  wr_addr;
    logic              wr_en;

    logic [PCNT_W-1:0] r_pop_count;
    logic [CNT_W-1:0]  n_cnt;
    logic [CNT_W-1:0]  r_n;
    logic [CNT_W-1:0]  r_rd_cnt;
    logic              r_pr_vld;
    logic [IDX_W-1:0]  r_pr_idx;
    logic              issue;
    logic              proc;
    logic              first;
    logic              last;
    logic              hit;

    logic [SUM_W-1:0]  r_acc;
    logic [SUM_W:0]    acc_sum;
    logic [SUM_W-1:0]  acc_add;
    logic [SUM_W-1:0]  r_stored_sum;
    logic [SUM_W-1:0]  r_limit;
    logic [PROD_W-1:0] prod;
    logic [FIT_W-1:0]  r_min;
    logic [FIT_W-1:0]  r_max;
    logic [IDX_W-1:0]  r_min_idx;
    logic [IDX_W-1:0]  r_max_idx;
    logic [IDX_W-1:0]  r_pick;

    logic              div_done;
    logic [SUM_W-1:0]  quo;
    logic [FIT_W-1:0]  avg;

    logic              r_o_valid;
    logic              r_o_kind;
    logic [EIDX_W-1:0] r_o_pick;
    logic [SUM_W-1:0]  r_o_sum;
    logic [FIT_W-1:0]  r_o_min;
    logic [EIDX_W-1:0] r_o_min_idx;
    logic [FIT_W-1:0]  r_o_max;
    logic [EIDX_W-1:0] r_o_max_idx;
    logic [FIT_W-1:0]  r_o_avg;

    // active entry count, clamped to 1..POP_MAX
    always_comb begin
        if (r_pop_count == '0) begin
            n_cnt = CNT_W'(1);
        end else if (32'(r_pop_count) > POP_MAX) begin
            n_cnt = CNT_W'(POP_MAX);
        end else begin
            n_cnt = CNT_W'(r_pop_count);
        end
    end

    // table write, writes past the table are dropped
    assign wr_addr = IDX_W'(i_entry_index);
    assign wr_en   = i_cmd.wr && (32'(i_entry_index) < POP_MAX);
    assign rd_addr = r_rd_cnt[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= i_fitness_value;
        end
        r_rd_data <= mem[rd_addr];
    end

    // scan step on the word read last cycle
    always_comb begin
        issue   = i_cmd.scan && (r_rd_cnt < r_n);
        proc    = i_cmd.scan && r_pr_vld;
        first   = (r_pr_idx == '0);
        last    = (CNT_W'(r_pr_idx) == (r_n - CNT_W'(1)));
        acc_sum = {1'b0, r_acc} + (SUM_W + 1)'(r_rd_data);
        acc_add = acc_sum[SUM_W] ? SUM_MAX : acc_sum[SUM_W-1:0];
        hit     = (acc_add >= r_limit);
        prod    = PROD_W'(i_random_fraction) * PROD_W'(r_stored_sum);
    end

    assign o_sts.scan_done = proc && (last || (i_cmd.sel && hit));

    // scan control and kept state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pop_count  <= PCNT_RST;
            r_stored_sum <= '0;
            r_rd_cnt     <= '0;
            r_pr_vld     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_pop_count <= i_cfg_data;
            end
            if (i_cmd.start) begin
                r_rd_cnt <= '0;
                r_pr_vld <= 1'b0;
            end else begin
                r_pr_vld <= issue;
                if (issue) begin
                    r_rd_cnt <= r_rd_cnt + CNT_W'(1);
                end
            end
            if (o_sts.scan_done && !i_cmd.sel) begin
                r_stored_sum <= acc_add;
            end
        end
    end

    // accumulators and extremes
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_n     <= n_cnt;
            r_acc   <= '0;
            r_limit <= prod[PROD_W-1:FIT_W];
        end else begin
            if (issue) begin
                r_pr_idx <= rd_addr;
            end
            if (proc) begin
                r_acc <= acc_add;
                if (first || (r_rd_data < r_min)) begin
                    r_min     <= r_rd_data;
                    r_min_idx <= r_pr_idx;
                end
                if (first || (r_rd_data > r_max)) begin
                    r_max     <= r_rd_data;
                    r_max_idx <= r_pr_idx;
                end
                r_pick <= r_pr_idx;
            end
        end
    end

    // average by serial division
    rws_div #(
        .DVS_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_acc),
        .i_divisor  (r_n),
        .o_done     (div_done),
        .o_quotient (quo)
    );

    assign avg              = (quo[SUM_W-1:FIT_W] != '0) ? AVG_MAX : quo[FIT_W-1:0];
    assign o_sts.div_done   = div_done;
    assign o_sts.out_free   = !r_o_valid || i_out_ready;

    // output word valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    // output word payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            if (i_cmd.sel) begin
                r_o_kind    <= KIND_SEL;
                r_o_pick    <= EIDX_W'(r_pick);
                r_o_sum     <= '0;
                r_o_min     <= '0;
                r_o_min_idx <= '0;
                r_o_max     <= '0;
                r_o_max_idx <= '0;
                r_o_avg     <= '0;
            end else begin
                r_o_kind    <= KIND_STAT;
                r_o_pick    <= '0;
                r_o_sum     <= r_acc;
                r_o_min     <= r_min;
                r_o_min_idx <= EIDX_W'(r_min_idx);
                r_o_max     <= r_max;
                r_o_max_idx <= EIDX_W'(r_max_idx);
                r_o_avg     <= avg;
            end
        end
    end

    assign o_out_valid    = r_o_valid;
    assign o_result_kind  = r_o_kind;
    assign o_picked_index = r_o_pick;
    assign o_fit_sum      = r_o_sum;
    assign o_min_fit      = r_o_min;
    assign o_min_index    = r_o_min_idx;
    assign o_max_fit      = r_o_max;
    assign o_max_index    = r_o_max_idx;
    assign o_avg_fit      = r_o_avg;

endmodule

// File: hw/rtl/rws_ctrl.sv
module rws_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic [rws_pkg::ACT_W-1:0] i_action,
    output logic                      o_in_ready,
    output rws_pkg::t_cmd             o_cmd,
    input  rws_pkg::t_sts             i_sts
);
    import rws_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_DIVGO = 3'd2;
    localparam logic [2:0] S_DIVW  = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_sel;
    logic       n_sel;
    logic       accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = o_in_ready && i_in_valid;

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_sel   = r_sel;
        o_cmd   = '0;
        o_cmd.sel = r_sel;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.sel = (i_action == ACT_SEL);
                if (accept) begin
                    o_cmd.wr = (i_action == ACT_WR);
                    if ((i_action == ACT_STAT) || (i_action == ACT_SEL)) begin
                        o_cmd.start = 1'b1;
                        n_sel       = (i_action == ACT_SEL);
                        n_state     = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = r_sel ? S_OUT : S_DIVGO;
                end
            end
            S_DIVGO: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIVW;
            end
            S_DIVW: begin
                if (i_sts.div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sel   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
        end
    end

endmodule

// File: hw/rtl/rws_chk.sv
`include "roulette_wheel_selector_assert.svh"

module rws_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_ready,
    input logic [rws_pkg::ACT_W-1:0]   i_action,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic                        o_result_kind,
    input logic [rws_pkg::EIDX_W-1:0]  o_picked_index,
    input logic [rws_pkg::SUM_W-1:0]   o_fit_sum,
    input logic [rws_pkg::FIT_W-1:0]   o_min_fit,
    input logic [rws_pkg::EIDX_W-1:0]  o_min_index,
    input logic [rws_pkg::FIT_W-1:0]   o_max_fit,
    input logic [rws_pkg::EIDX_W-1:0]  o_max_index,
    input logic [rws_pkg::FIT_W-1:0]   o_avg_fit
);
    import rws_pkg::*;

    localparam int WORD_W = 2 + 3 * EIDX_W + SUM_W + 3 * FIT_W;

    logic [WORD_W-1:0] out_word;
    logic              stalled;
    logic              sel_out;
    logic              stat_out;
    logic              sel_zero;
    logic              stat_ok;
    logic              wr_taken;

    // result channel as seen by the receiver
    assign out_word = {o_out_valid, o_result_kind, o_picked_index, o_fit_sum, o_min_fit,
                       o_min_index, o_max_fit, o_max_index, o_avg_fit};
    assign stalled  = o_out_valid && !i_out_ready;
    assign sel_out  = o_out_valid && (o_result_kind == KIND_SEL);
    assign stat_out = o_out_valid && (o_result_kind == KIND_STAT);
    assign sel_zero = (o_fit_sum == '0) && (o_min_fit == '0) && (o_max_fit == '0)
                   && (o_avg_fit == '0) && (o_min_index == '0) && (o_max_index == '0);
    assign stat_ok  = (o_picked_index == '0) && (o_min_fit <= o_max_fit)
                   && (o_avg_fit <= o_max_fit);
    assign wr_taken = i_in_valid && o_in_ready && (i_action == ACT_WR);

    // a stalled result word holds
    `RWS_ASSERT_NEXT(a_out_hold, stalled, $stable(out_word), "result word changed while stalled")

    // a selection word carries no statistics
    `RWS_ASSERT_SAME(a_sel_clean, sel_out, sel_zero, "selection word has statistics fields set")

    // statistics are ordered: min <= max, average <= max, no pick
    `RWS_ASSERT_SAME(a_stat_order, stat_out, stat_ok, "statistics word out of order")

    // a write word never produces a result
    `RWS_ASSERT_NEXT(a_wr_silent, wr_taken, !$rose(o_out_valid), "write word produced a result")

    // a new result follows only a word in work, while the input was not ready
    `RWS_ASSERT_SAME(a_out_busy, $rose(o_out_valid), $past(!o_in_ready), "no word in work")

endmodule

bind roulette_wheel_selector rws_chk u_rws_chk (.*);
